// ----- rtl/key_matrix_change_detector_defines.svh -----
// assertion macros for the key matrix change detector checker
`ifndef KEY_MATRIX_CHANGE_DETECTOR_DEFINES_SVH
`define KEY_MATRIX_CHANGE_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KMCD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kmcd check failed");

// next-cycle implication, sampled on clk, off during reset
`define KMCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kmcd check failed");

`endif

// ----- rtl/kmcd_pkg.sv -----
// shared constants, types and helper functions for the key matrix change detector
`timescale 1ns / 1ps

package kmcd_pkg;

	localparam int MAX_ROWS  = 8;
	localparam int MAX_COLS  = 8;
	localparam int KEY_W     = 8;
	localparam int IDX_W     = $clog2(KEY_W);
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS = 2'd0,
		REG_NUM_COLS = 2'd1
	} cfg_reg_t;

	// row unit control from the sequencer
	typedef struct packed {
		logic [IDX_W-1:0] addr;
		logic             wr_en;
	} unit_ctl_t;

	// mask of the low n bits, counts above the limit saturate
	function automatic logic [KEY_W-1:0] low_mask(input logic [CNT_W-1:0] n,
			input logic [CNT_W-1:0] limit);
		logic [CNT_W-1:0] m;
		logic [KEY_W:0]   t;
		m = (n > limit) ? limit : n;
		if (m >= CNT_W'(KEY_W)) begin
			t = {1'b0, {KEY_W{1'b1}}};
		end else begin
			t = ((KEY_W+1)'(1) << m) - (KEY_W+1)'(1);
		end
		return t[KEY_W-1:0];
	endfunction

	// index of the lowest set bit, zero when none
	function automatic logic [IDX_W-1:0] lowest_bit(input logic [KEY_W-1:0] v);
		logic [IDX_W-1:0] res;
		res = '0;
		for (int i = KEY_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				res = IDX_W'(i);
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/kmcd_row_unit.sv -----
// per-row key state storage and the shared compare unit
`timescale 1ns / 1ps

module kmcd_row_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kmcd_pkg::unit_ctl_t       ctl,
	input  logic [kmcd_pkg::KEY_W-1:0] levels,
	input  logic [kmcd_pkg::KEY_W-1:0] col_mask,
	output logic [kmcd_pkg::KEY_W-1:0] changed
);
	import kmcd_pkg::*;

	logic [KEY_W-1:0] key_state_q [MAX_ROWS];
	logic [KEY_W-1:0] cur_row;

	assign cur_row = key_state_q[ctl.addr];
	assign changed = (cur_row ^ levels) & col_mask;

	// unused columns keep their stored level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++) begin
				key_state_q[r] <= '1;
			end
		end else if (ctl.wr_en) begin
			key_state_q[ctl.addr] <= (cur_row & ~col_mask) | (levels & col_mask);
		end
	end

endmodule

// ----- rtl/kmcd_seq.sv -----
// scan sequencer: row pass, then one event per cycle into the output register unless the receiver stalls
`timescale 1ns / 1ps

module kmcd_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [kmcd_pkg::KEY_W-1:0] row_mask,
	input  logic [kmcd_pkg::KEY_W-1:0] col_levels,
	input  logic [kmcd_pkg::KEY_W-1:0] row_mask_cfg,
	input  logic [kmcd_pkg::KEY_W-1:0] col_mask_cfg,
	output kmcd_pkg::unit_ctl_t        unit_ctl,
	output logic [kmcd_pkg::KEY_W-1:0] unit_levels,
	output logic [kmcd_pkg::KEY_W-1:0] unit_col_mask,
	input  logic [kmcd_pkg::KEY_W-1:0] changed,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [kmcd_pkg::IDX_W-1:0] key_row,
	output logic [kmcd_pkg::IDX_W-1:0] key_col,
	output logic                       pressed,
	output logic                       last
);
	import kmcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ROW,
		ST_COLS
	} state_t;

	state_t           state_q;
	logic [KEY_W-1:0] row_bits_q;
	logic [KEY_W-1:0] levels_q;
	logic [KEY_W-1:0] col_mask_q;
	logic [KEY_W-1:0] hit_q;
	logic [KEY_W-1:0] col_left_q;
	logic [IDX_W-1:0] row_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] key_row_q;
	logic [IDX_W-1:0] key_col_q;
	logic             pressed_q;
	logic             last_q;

	logic [IDX_W-1:0] pick_row;
	logic [IDX_W-1:0] col_pick;
	logic [KEY_W-1:0] col_rem;
	logic             load_ok;
	logic             emit_ev;

	assign pick_row = lowest_bit(hit_q);
	assign col_pick = lowest_bit(col_left_q);
	assign col_rem  = col_left_q & ~(KEY_W'(1) << col_pick);
	assign load_ok  = !out_valid_q || out_ready;
	assign emit_ev  = (state_q == ST_COLS) && load_ok;

	assign in_ready      = (state_q == ST_IDLE);
	assign unit_levels   = levels_q;
	assign unit_col_mask = col_mask_q;

	always_comb begin
		unit_ctl.addr  = (state_q == ST_ROW) ? pick_row : row_q;
		unit_ctl.wr_en = (state_q == ST_ROW) && (hit_q != '0);
	end

	assign out_valid = out_valid_q;
	assign key_row   = key_row_q;
	assign key_col   = key_col_q;
	assign pressed   = pressed_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_bits_q  <= '0;
			levels_q    <= '0;
			col_mask_q  <= '0;
			hit_q       <= '0;
			col_left_q  <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			key_row_q   <= '0;
			key_col_q   <= '0;
			pressed_q   <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (emit_ev) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						row_bits_q <= row_mask & row_mask_cfg;
						levels_q   <= col_levels;
						col_mask_q <= col_mask_cfg;
						hit_q      <= '0;
						row_q      <= '0;
						state_q    <= ST_SCAN;
					end
				end
				// first pass: flag each tested row that has a changed column
				ST_SCAN: begin
					hit_q[row_q] <= row_bits_q[row_q] & (|changed);
					row_q        <= row_q + IDX_W'(1);
					if (row_q == IDX_W'(MAX_ROWS - 1)) begin
						state_q <= ST_ROW;
					end
				end
				// pick next flagged row, latch its changes and store new levels; back to idle when none is left
				ST_ROW: begin
					if (hit_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						row_q           <= pick_row;
						col_left_q      <= changed;
						hit_q[pick_row] <= 1'b0;
						state_q         <= ST_COLS;
					end
				end
				ST_COLS: begin
					if (load_ok) begin
						key_row_q   <= row_q;
						key_col_q   <= col_pick;
						pressed_q   <= ~levels_q[col_pick];
						last_q      <= (col_rem == '0) && (hit_q == '0);
						col_left_q  <= col_rem;
						if (col_rem == '0) begin
							state_q <= (hit_q == '0) ? ST_IDLE : ST_ROW;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/key_matrix_change_detector.sv -----
// key matrix change detector top level: config registers, sequencer, row unit
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   row_mask, col_levels
// out       output     out_valid / out_ready key_row, key_col, pressed, last
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a sample goes through a row pass over all 8 rows in the single compare unit,
// then a step per changed row and a step per event through the output register;
// when nothing changed it ends after the row pass.
// reset sets every stored row to all ones and num_rows, num_cols to 8.
// out_ready low holds the sequencer on the pending event; in_ready is high
// again once the last word of a sample sits in the output register.
`timescale 1ns / 1ps

module key_matrix_change_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     row_mask,
	input  logic [7:0]                     col_levels,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     key_row,
	output logic [2:0]                     key_col,
	output logic                           pressed,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kmcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kmcd_pkg::CNT_W-1:0]     cfg_data
);
	import kmcd_pkg::*;

	logic [CNT_W-1:0] num_rows_q;
	logic [CNT_W-1:0] num_cols_q;
	logic [KEY_W-1:0] row_mask_cfg;
	logic [KEY_W-1:0] col_mask_cfg;
	unit_ctl_t        unit_ctl;
	logic [KEY_W-1:0] unit_levels;
	logic [KEY_W-1:0] unit_col_mask;
	logic [KEY_W-1:0] changed;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CNT_W'(MAX_ROWS);
			num_cols_q <= CNT_W'(MAX_COLS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_ROWS: begin
					num_rows_q <= cfg_data;
				end
				REG_NUM_COLS: begin
					num_cols_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign row_mask_cfg = low_mask(num_rows_q, CNT_W'(MAX_ROWS));
	assign col_mask_cfg = low_mask(num_cols_q, CNT_W'(MAX_COLS));

	kmcd_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.row_mask      (row_mask),
		.col_levels    (col_levels),
		.row_mask_cfg  (row_mask_cfg),
		.col_mask_cfg  (col_mask_cfg),
		.unit_ctl      (unit_ctl),
		.unit_levels   (unit_levels),
		.unit_col_mask (unit_col_mask),
		.changed       (changed),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.key_row       (key_row),
		.key_col       (key_col),
		.pressed       (pressed),
		.last          (last)
	);

	kmcd_row_unit u_row_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (unit_ctl),
		.levels   (unit_levels),
		.col_mask (unit_col_mask),
		.changed  (changed)
	);

endmodule

// ----- rtl/kmcd_checker.sv -----
// port-level checks for the key matrix change detector, bound to the top level
`timescale 1ns / 1ps
`include "key_matrix_change_detector_defines.svh"

module kmcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] key_row,
	input logic [2:0] key_col,
	input logic       pressed,
	input logic       last
);
	// a stalled word holds
	`KMCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(key_row) && $stable(key_col) && $stable(pressed) && $stable(last))
	// a taken sample drops in_ready
	`KMCD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// while a word that is not the last waits, more events of that sample are pending
	`KMCD_ASSERT_NOW(a_not_last_busy, out_valid && !last, !in_ready)
	// returning to idle leaves at most the closing word of a sample
	`KMCD_ASSERT_NOW(a_idle_last, $rose(in_ready), !out_valid || last)

endmodule

bind key_matrix_change_detector kmcd_checker u_kmcd_checker (.*);

// ----- tb/key_matrix_change_detector_tb.sv -----
// testbench for the key matrix change detector: predicted key events checked word by word
`timescale 1ns / 1ps

module key_matrix_change_detector_tb;

	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 400;
	localparam int RESET_CYCLES  = 11;

	// indexes with no register behind them
	localparam logic [kmcd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [kmcd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
		logic       down;
		logic       fin;
	} key_event_t;

	class key_event_board;
		logic [7:0] key_levels [8];
		logic [3:0] rows_cfg;
		logic [3:0] cols_cfg;
		key_event_t pending_events [$];
		int         errors;

		function new();
			for (int r = 0; r < 8; r++) begin
				key_levels[r] = 8'hFF;
			end
			rows_cfg = 4'd8;
			cols_cfg = 4'd8;
			errors   = 0;
		endfunction

		function void set_reg(logic [kmcd_pkg::CFG_IDX_W-1:0] idx, logic [3:0] data);
			case (idx)
				kmcd_pkg::REG_NUM_ROWS: rows_cfg = data;
				kmcd_pkg::REG_NUM_COLS: cols_cfg = data;
				default: ;
			endcase
		endfunction

		// events for one sample, lowest row then lowest column first
		function void note_sample(logic [7:0] rmask, logic [7:0] levels);
			logic [7:0] col_mask;
			logic [7:0] rows_on;
			logic [7:0] diff [8];
			int         rows_used;
			int         cols_used;
			int         total;
			int         seen;
			key_event_t ev;
			rows_used = (rows_cfg > 4'd8) ? 8 : int'(rows_cfg);
			cols_used = (cols_cfg > 4'd8) ? 8 : int'(cols_cfg);
			col_mask  = (cols_used >= 8) ? 8'hFF : 8'((1 << cols_used) - 1);
			rows_on   = rmask & ((rows_used >= 8) ? 8'hFF : 8'((1 << rows_used) - 1));
			total = 0;
			for (int r = 0; r < 8; r++) begin
				diff[r] = rows_on[r] ? ((key_levels[r] ^ levels) & col_mask) : 8'h00;
				total += $countones(diff[r]);
			end
			seen = 0;
			for (int r = 0; r < 8; r++) begin
				for (int c = 0; c < 8; c++) begin
					if (diff[r][c]) begin
						seen++;
						ev.row  = 3'(r);
						ev.col  = 3'(c);
						ev.down = !levels[c];
						ev.fin  = (seen == total);
						pending_events.push_back(ev);
					end
				end
				// unused columns keep their stored level
				if (rows_on[r]) begin
					key_levels[r] = (key_levels[r] & ~col_mask) | (levels & col_mask);
				end
			end
		endfunction

		function void report(string field, int want, int got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_event(logic [2:0] row, logic [2:0] col, logic down, logic fin);
			key_event_t want;
			if (pending_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual row %0d col %0d pressed %0b last %0b",
					$time, row, col, down, fin);
				return;
			end
			want = pending_events.pop_front();
			if (want.row != row) report("key_row", want.row, row);
			if (want.col != col) report("key_col", want.col, col);
			if (want.down != down) report("pressed", want.down, down);
			if (want.fin != fin) report("last", want.fin, fin);
		endfunction
	endclass

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           in_valid   = 1'b0;
	logic                           in_ready;
	logic [7:0]                     row_mask   = 8'h00;
	logic [7:0]                     col_levels = 8'h00;
	logic                           out_valid;
	logic                           out_ready  = 1'b0;
	logic [2:0]                     key_row;
	logic [2:0]                     key_col;
	logic                           pressed;
	logic                           last;
	logic                           cfg_valid  = 1'b0;
	logic                           cfg_ready;
	logic [kmcd_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
	logic [kmcd_pkg::CNT_W-1:0]     cfg_data   = '0;

	int   idle_pct    = 0;
	int   stall_pct   = 0;
	logic hold_rx     = 1'b0;
	int   quiet_count = 0;

	key_event_board board = new();

	key_matrix_change_detector DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.row_mask   (row_mask),
		.col_levels (col_levels),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_row    (key_row),
		.key_col    (key_col),
		.pressed    (pressed),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) board.note_sample(row_mask, col_levels);
			if (out_valid && out_ready) board.check_event(key_row, key_col, pressed, last);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_count <= 0;
		end else begin
			quiet_count <= quiet_count + 1;
		end
		if (quiet_count >= QUIET_LIMIT) begin
			$display("[key_matrix_change_detector] ERROR");
			$finish;
		end
	end

	task automatic send_sample(input logic [7:0] rm, input logic [7:0] cl);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		row_mask   <= rm;
		col_levels <= cl;
		do @(posedge clk); while (!in_ready);
	endtask

	// leaves cfg_valid high so back-to-back writes need no gap
	task automatic write_reg(input logic [kmcd_pkg::CFG_IDX_W-1:0] idx, input logic [3:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// zero-event samples may still be in flight when the queue runs dry
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [3:0] rows, input logic [3:0] cols);
		quiesce();
		write_reg(kmcd_pkg::REG_NUM_ROWS, rows);
		write_reg(kmcd_pkg::REG_NUM_COLS, cols);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [3:0] pick_count();
		case ($urandom_range(11))
			0:       return 4'd0;
			1:       return 4'($urandom_range(15, 9));
			default: return 4'($urandom_range(8, 1));
		endcase
	endfunction

	initial begin
		logic [7:0] cur_levels;
		logic [7:0] rm;
		logic [7:0] cl;
		int         pick;
		int         idle_set  [4];
		int         stall_set [4];

		idle_set  = '{0, 76, 0, 26};
		stall_set = '{0, 0, 76, 26};
		cur_levels = 8'hFF;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full matrix: every key down, repeat, release by row, single row, no row, release all
		send_sample(8'hFF, 8'h00);
		send_sample(8'hFF, 8'h00);
		send_sample(8'h01, 8'hFF);
		send_sample(8'h80, 8'hAA);
		send_sample(8'h00, 8'h55);
		send_sample(8'hFF, 8'hFF);

		// partial matrix, masked bits ignored
		configure(4'd3, 4'd5);
		send_sample(8'hFF, 8'h00);
		send_sample(8'h04, 8'h1F);
		// wider columns later: rows 0 and 1 report only the newly used columns
		configure(4'd3, 4'd8);
		send_sample(8'h07, 8'h00);

		// no rows, then no columns
		configure(4'd0, 4'd8);
		send_sample(8'hFF, 8'hFF);
		configure(4'd8, 4'd0);
		send_sample(8'hFF, 8'hAA);

		// oversized counts saturate
		configure(4'd15, 4'd9);
		send_sample(8'hFF, 8'hFF);

		// writes to unused indexes change nothing
		quiesce();
		write_reg(REG_SPARE_A, 4'd1);
		write_reg(REG_SPARE_B, 4'd2);
		cfg_valid <= 1'b0;
		send_sample(8'hF0, 8'h0F);

		configure(4'd1, 4'd1);
		send_sample(8'hFF, 8'hFE);
		send_sample(8'h01, 8'hFF);

		// receiver holds off while full-matrix samples keep coming
		configure(4'd8, 4'd8);
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		for (int i = 0; i < 8; i++) begin
			send_sample(8'hFF, (i % 2 == 0) ? 8'h00 : 8'hFF);
		end

		for (int ph = 0; ph < 8; ph++) begin
			configure(pick_count(), pick_count());
			idle_pct  = idle_set[ph / 2];
			stall_pct <= stall_set[ph / 2];
			for (int i = 0; i < 31; i++) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					// scan of one row with a key or two toggling
					rm = 8'h01 << $urandom_range(7);
					cl = cur_levels ^ (8'h01 << $urandom_range(7));
					if ($urandom_range(3) == 0) cl = cl ^ (8'h01 << $urandom_range(7));
					cur_levels = cl;
				end else if (pick < 80) begin
					rm = 8'($urandom_range(255));
					cl = 8'($urandom_range(255));
				end else begin
					rm = ($urandom_range(1) == 0) ? 8'hFF : 8'($urandom_range(255));
					cl = ~cur_levels;
					cur_levels = cl;
				end
				send_sample(rm, cl);
			end
		end

		quiesce();
		if (board.errors == 0) begin
			$display("[key_matrix_change_detector] OK");
		end else begin
			$display("[key_matrix_change_detector] ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/kmcd_pkg.sv
rtl/kmcd_row_unit.sv
rtl/kmcd_seq.sv
rtl/key_matrix_change_detector.sv
rtl/kmcd_checker.sv
tb/key_matrix_change_detector_tb.sv
